[hw/rtl/ils_pkg.sv]
// shared types and constants for the indexed list store
`timescale 1ns / 1ps

package ils_pkg;

  // most entries the store can hold
  localparam int unsigned Capacity = 16;

  // field widths of the request and result items
  localparam int unsigned ActionW = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CountW  = 5;

  // internal widths that follow from the capacity
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned SlotW = $clog2(Capacity);

  typedef enum logic [ActionW-1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef logic signed [ValueW-1:0] value_t;

  // per-cell load controls
  typedef struct packed {
    logic load;   // take the appended value
    logic shift;  // take the neighbor toward the tail
  } cell_ctrl_t;

endpackage

[hw/rtl/ils_req_if.sv]
// request channel of the indexed list store
`timescale 1ns / 1ps

interface ils_req_if;
  logic                           valid;
  logic                           ready;
  logic [ils_pkg::ActionW-1:0]    action;
  logic signed [ils_pkg::ValueW-1:0] value;
  logic [ils_pkg::IndexW-1:0]     index;

  modport source (output valid, action, value, index, input ready);
  modport sink (input valid, action, value, index, output ready);
endinterface

[hw/rtl/ils_res_if.sv]
// result channel of the indexed list store
`timescale 1ns / 1ps

interface ils_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [ils_pkg::ValueW-1:0] data_out;
  logic                              ok;
  logic [ils_pkg::CountW-1:0]        count;
  logic                              empty_res;

  modport source (output valid, data_out, ok, count, empty_res, input ready);
  modport sink (input valid, data_out, ok, count, empty_res, output ready);
endinterface

[hw/rtl/ils_cell.sv]
// one storage cell of the list: holds an entry, loads a new value or its neighbor
`timescale 1ns / 1ps

module ils_cell (
  input  logic                clk_i,
  input  ils_pkg::cell_ctrl_t ctrl_i,
  input  ils_pkg::value_t     append_value_i,
  input  ils_pkg::value_t     neighbor_i,
  output ils_pkg::value_t     data_o
);

  ils_pkg::value_t data_q;
  ils_pkg::value_t data_d;

  always_comb begin
    priority if (ctrl_i.load) begin
      data_d = append_value_i;
    end else if (ctrl_i.shift) begin
      data_d = neighbor_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[hw/rtl/indexed_list_store.sv]
// indexed list store: the result is registered and valid in the cycle after the request is taken
// throughput 1 request per cycle while the result side takes every result
// on a removal, every entry at or past the position moves one place toward the head in the same cycle
// the row of cells, one per entry, sets that rate: each cell is a plain register with no stall
// reset clears the entry count and the result valid; entry contents are left as is
`timescale 1ns / 1ps

module indexed_list_store (
  input  logic       clk_i,
  input  logic       rst_ni,
  ils_req_if.sink    in_i,
  ils_res_if.source  out_o
);

  localparam int unsigned Cap = ils_pkg::Capacity;

  // entry count and result register
  logic [ils_pkg::CntW-1:0]   count_q, count_d;
  logic                       res_valid_q;
  ils_pkg::value_t            res_data_q, res_data_d;
  logic                       res_ok_q, res_ok_d;
  logic [ils_pkg::CountW-1:0] res_count_q;
  logic                       res_empty_q;

  // request decode
  logic                  accept;
  logic                  is_append, is_remove, is_read;
  logic                  full;
  logic                  pos_ok;
  logic [ils_pkg::SlotW-1:0] slot;

  // row of cells
  ils_pkg::value_t    cell_data [Cap];
  ils_pkg::cell_ctrl_t cell_ctrl [Cap];

  // new request goes in when the result register is free or drains this cycle
  assign in_i.ready = !res_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    is_append = 1'b0;
    is_remove = 1'b0;
    is_read   = 1'b0;
    unique case (ils_pkg::action_e'(in_i.action))
      ils_pkg::ACT_APPEND: is_append = 1'b1;
      ils_pkg::ACT_REMOVE: is_remove = 1'b1;
      ils_pkg::ACT_READ:   is_read   = 1'b1;
      ils_pkg::ACT_NONE:   ;
      default:             ;
    endcase
  end

  assign full   = (32'(count_q) >= 32'(Cap));
  // position valid only below the count
  assign pos_ok = (32'(in_i.index) < 32'(count_q));
  assign slot   = ils_pkg::SlotW'(in_i.index);

  // per-cell controls: append lands at the tail slot, removal pulls every
  // cell at or past the position from its neighbor toward the tail
  for (genvar i = 0; i < Cap; i++) begin : g_cell
    ils_pkg::value_t neighbor;

    assign cell_ctrl[i].load  = accept && is_append && !full &&
                                (32'(count_q) == 32'(i));
    assign cell_ctrl[i].shift = accept && is_remove && pos_ok &&
                                (32'(i) >= 32'(in_i.index));

    if (i == Cap - 1) begin : g_last
      // tail cell keeps its value, it falls outside the count after removal
      assign neighbor = cell_data[i];
    end else begin : g_inner
      assign neighbor = cell_data[i+1];
    end

    ils_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (cell_ctrl[i]),
      .append_value_i (in_i.value),
      .neighbor_i     (neighbor),
      .data_o         (cell_data[i])
    );
  end

  // result and next count
  always_comb begin
    count_d    = count_q;
    res_data_d = '0;
    res_ok_d   = 1'b0;
    if (is_append && !full) begin
      count_d  = count_q + ils_pkg::CntW'(1);
      res_ok_d = 1'b1;
    end else if ((is_remove || is_read) && pos_ok) begin
      res_data_d = cell_data[slot];
      res_ok_d   = 1'b1;
      if (is_remove) begin
        count_d = count_q - ils_pkg::CntW'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_data_q  <= res_data_d;
      res_ok_q    <= res_ok_d;
      res_count_q <= ils_pkg::CountW'(count_d);
      res_empty_q <= (count_d == '0);
    end
  end

  assign out_o.valid     = res_valid_q;
  assign out_o.data_out  = res_data_q;
  assign out_o.ok        = res_ok_q;
  assign out_o.count     = res_count_q;
  assign out_o.empty_res = res_empty_q;

endmodule
